// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMOF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rmof_pkg.sv -----
`default_nettype none

package rmof_pkg;

    localparam int DATA_W    = 16;
    localparam int FILL_W    = 3;
    localparam int RUN_W     = 8;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 1;

    typedef logic [DATA_W-1:0]    t_sample;
    typedef logic [RUN_W-1:0]     t_run;
    typedef logic [TOTAL_W-1:0]   t_total;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_JUMP_GATE      = 1'b0;
    localparam t_cfg_idx CFG_OUTLIER_ACCEPT = 1'b1;

    localparam t_sample GATE_RESET   = 16'd400;
    localparam t_run    ACCEPT_RESET = 8'd3;

    // Status from the statistics engine back to the top level
    typedef struct packed {
        logic    done;
        t_sample median;
        t_sample spread;
    } t_stats_res;

endpackage

`default_nettype wire

// ----- hdl/robust_median_outlier_filter.sv -----
// Median filter with an outlier gate for distance samples in millimetres.
// Input channel: i_in_valid / o_in_ready carry one i_sample_mm per beat.
// Output channel: o_out_valid / i_out_ready carry one result beat per input
// beat: median, fill count, spread, rejected flag and running reject total.
// Config channel: i_cfg_valid / o_cfg_ready (always high), index 0 writes the
// jump gate, index 1 the outlier run length; write only while the block idles.
// A taken sample with n entries in the window is sorted by one compare-
// exchange unit, one compare per cycle in bubble passes over a rotating line,
// then scanned once for min, middle and max. A dropped outlier skips the sort.
// One item at a time: o_in_ready is high only between items, so a new beat is
// taken only after the previous result is loaded into the output register;
// the next item may enter while that result still waits in the register.
// If the receiver stalls, the result holds in the output register and the
// next finished result waits in the block until the register frees.
// Reset (synchronous, active low) empties the window, clears the run and the
// reject total and restores the gate to 400 mm and the run length to 3.
`default_nettype none

module robust_median_outlier_filter
    import rmof_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_sample         i_sample_mm,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_sample         o_median_mm,
    output logic [FILL_W-1:0] o_fill_count,
    output t_sample         o_spread_mm,
    output logic            o_was_rejected,
    output t_total          o_reject_total,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  t_cfg_idx        i_cfg_index,
    input  t_sample         i_cfg_data
);

    localparam int HELD_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(WINDOW);
    localparam logic [HELD_W-1:0] HELD_ONE  = HELD_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    typedef enum logic [1:0] {S_IDLE, S_BUSY, S_SEND} t_state;

    t_state               r_state;
    t_sample              r_window [WINDOW];
    logic [SLOT_W-1:0]    r_slot;
    logic [HELD_W-1:0]    r_held;
    t_run                 r_run;
    t_total               r_reject_cnt;
    t_sample              r_gate;
    t_run                 r_accept;
    logic                 r_rejected;
    logic                 r_start;

    logic                 r_out_valid;
    t_sample              r_out_median;
    logic [FILL_W-1:0]    r_out_fill;
    t_sample              r_out_spread;
    logic                 r_out_rejected;
    t_total               r_out_total;

    t_stats_res           stats_res;
    t_sample              diff_mm;
    t_run                 run_inc;
    logic                 is_full;
    logic                 is_outlier;
    logic                 drop;
    logic                 restart;
    logic [SLOT_W-1:0]    wr_slot;
    logic                 out_beat;
    logic                 out_load;

    // Median, spread and sort live in the engine; its median is the held state
    rmof_stats #(
        .WINDOW (WINDOW)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_count  (r_held),
        .i_window (r_window),
        .o_res    (stats_res)
    );

    // Gate: distance from the held median, only once the window is full
    assign diff_mm    = (i_sample_mm > stats_res.median) ? (i_sample_mm - stats_res.median)
                                                         : (stats_res.median - i_sample_mm);
    assign run_inc    = r_run + 1'b1;
    assign is_full    = (r_held == HELD_FULL);
    assign is_outlier = is_full && (diff_mm > r_gate);
    // drop while the run is short; a run that reaches the limit restarts the window
    assign drop       = is_outlier && (run_inc < r_accept);
    assign restart    = is_outlier && !drop;
    assign wr_slot    = restart ? '0 : r_slot;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_beat   = r_out_valid && i_out_ready;
    // the output register takes a new beat once it is free or being emptied
    assign out_load   = (r_state == S_SEND) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_held       <= '0;
            r_run        <= '0;
            r_reject_cnt <= '0;
            r_gate       <= GATE_RESET;
            r_accept     <= ACCEPT_RESET;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // kick the engine for every sample that enters the window
            r_start <= (r_state == S_IDLE) && i_in_valid && !drop;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_JUMP_GATE:      r_gate   <= i_cfg_data;
                    CFG_OUTLIER_ACCEPT: r_accept <= i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end

            // load a fresh result beat, or drop the one just taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rejected <= drop;
                        if (drop) begin
                            // hold window and statistics, count the reject
                            r_run        <= run_inc;
                            r_reject_cnt <= r_reject_cnt + 1'b1;
                            r_state      <= S_SEND;
                        end else begin
                            r_run             <= '0;
                            r_window[wr_slot] <= i_sample_mm;
                            r_slot  <= (wr_slot == SLOT_LAST) ? '0 : wr_slot + 1'b1;
                            if (restart) begin
                                r_held <= HELD_ONE;
                            end else if (!is_full) begin
                                r_held <= r_held + HELD_ONE;
                            end
                            r_state <= S_BUSY;
                        end
                    end
                end
                S_BUSY: begin
                    if (stats_res.done) begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    // advance only when the output register is free
                    if (out_load) begin
                        r_out_median   <= stats_res.median;
                        r_out_fill     <= FILL_W'(r_held);
                        r_out_spread   <= stats_res.spread;
                        r_out_rejected <= r_rejected;
                        r_out_total    <= r_reject_cnt;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_mm    = r_out_median;
    assign o_fill_count   = r_out_fill;
    assign o_spread_mm    = r_out_spread;
    assign o_was_rejected = r_out_rejected;
    assign o_reject_total = r_out_total;

endmodule

`default_nettype wire

// ----- hdl/rmof_stats.sv -----
`default_nettype none

module rmof_stats
    import rmof_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(WINDOW + 1)-1:0]  i_count,
    input  t_sample                        i_window [WINDOW],
    output t_stats_res                     o_res
);

    localparam int HELD_W = $clog2(WINDOW + 1);
    localparam int LINE_D = WINDOW + 1;
    localparam logic [HELD_W-1:0] CNT_ONE = HELD_W'(1);
    localparam logic [HELD_W-1:0] CNT_TWO = HELD_W'(2);

    typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_SCAN, ST_CALC} t_state;

    t_state              r_state;
    t_sample             r_line [LINE_D];
    t_sample             r_carry;
    logic [HELD_W-1:0]   r_n;
    logic [HELD_W-1:0]   r_pass;
    logic [HELD_W-1:0]   r_step;
    t_sample             r_min;
    t_sample             r_max;
    t_sample             r_lo;
    t_sample             r_hi;
    t_sample             r_median;
    t_sample             r_spread;
    logic                r_done;

    // Shared compare-exchange unit: carried value against the line head
    logic                do_swap;
    t_sample             small_val;
    t_sample             big_val;
    logic [HELD_W-1:0]   half;
    logic [DATA_W:0]     mid_sum;

    assign do_swap   = r_carry > r_line[1];
    assign small_val = do_swap ? r_line[1] : r_carry;
    assign big_val   = do_swap ? r_carry : r_line[1];
    assign half      = r_n >> 1;
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_median <= '0;
            r_spread <= '0;
        end else begin
            r_done <= (r_state == ST_CALC);
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        for (int k = 0; k < WINDOW; k++) begin
                            r_line[k] <= i_window[k];
                        end
                        r_carry <= i_window[0];
                        r_n     <= i_count;
                        r_pass  <= '0;
                        if (i_count > CNT_ONE) begin
                            r_step  <= CNT_ONE;
                            r_state <= ST_SORT;
                        end else begin
                            r_step  <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SORT: begin
                    // rotate the line; the tail slot takes the exchange output
                    for (int k = 0; k < LINE_D - 1; k++) begin
                        if (HELD_W'(k) != r_n - CNT_ONE) begin
                            r_line[k] <= r_line[k + 1];
                        end
                    end
                    if (r_step == r_n) begin
                        // close the pass: park the largest at the tail
                        r_line[r_n - CNT_ONE] <= r_carry;
                        r_carry <= r_line[1];
                        if (r_pass == r_n - CNT_TWO) begin
                            r_step  <= '0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_pass <= r_pass + CNT_ONE;
                            r_step <= CNT_ONE;
                        end
                    end else begin
                        r_line[r_n - CNT_ONE] <= small_val;
                        r_carry <= big_val;
                        r_step  <= r_step + CNT_ONE;
                    end
                end
                ST_SCAN: begin
                    for (int k = 0; k < LINE_D - 1; k++) begin
                        r_line[k] <= r_line[k + 1];
                    end
                    if (r_step == '0) begin
                        r_min <= r_line[0];
                    end
                    if (r_step == half) begin
                        r_hi <= r_line[0];
                        if (r_n[0]) begin
                            r_lo <= r_line[0];
                        end
                    end
                    if (!r_n[0] && (r_step == half - CNT_ONE)) begin
                        r_lo <= r_line[0];
                    end
                    if (r_step == r_n - CNT_ONE) begin
                        r_max   <= r_line[0];
                        r_state <= ST_CALC;
                    end
                    r_step <= r_step + CNT_ONE;
                end
                ST_CALC: begin
                    r_median <= mid_sum[DATA_W:1];
                    r_spread <= r_max - r_min;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.done   = r_done;
    assign o_res.median = r_median;
    assign o_res.spread = r_spread;

endmodule

`default_nettype wire

// ----- hdl/rmof_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module rmof_checker #(
    parameter int WINDOW = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] o_median_mm,
    input  logic [2:0]  o_fill_count,
    input  logic [15:0] o_spread_mm,
    input  logic        o_was_rejected,
    input  logic [31:0] o_reject_total
);

    // A beat is only ever dropped against a full window
    `RMOF_ASSERT_SAME(a_reject_needs_full, o_out_valid && o_was_rejected, o_fill_count == 3'(WINDOW), "rejected beat with window not full")

    // One entry or none has no spread
    `RMOF_ASSERT_SAME(a_spread_single, (WINDOW < 8) && o_out_valid && (o_fill_count <= 3'd1), o_spread_mm == 16'd0, "spread non-zero with fewer than two entries")

    // One item at a time: ready drops after an input beat
    `RMOF_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "input taken while an item is in flight")

    // Stalled result holds
    `RMOF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_median_mm) && $stable(o_reject_total), "result beat changed under stall")

endmodule

bind robust_median_outlier_filter rmof_checker #(
    .WINDOW (WINDOW)
) u_rmof_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_median_mm    (o_median_mm),
    .o_fill_count   (o_fill_count),
    .o_spread_mm    (o_spread_mm),
    .o_was_rejected (o_was_rejected),
    .o_reject_total (o_reject_total)
);

`default_nettype wire

// ----- tb/median_check_pkg.sv -----
package median_check_pkg;
    import rmof_pkg::*;

    localparam int WINDOW_DEPTH = 5;

    typedef struct {
        t_sample           median;
        logic [FILL_W-1:0] fill;
        t_sample           spread;
        logic              rejected;
        t_total            total;
    } t_filter_result;

    class median_filter_checker;
        t_sample        window_mm [WINDOW_DEPTH];
        int unsigned    next_slot;
        int unsigned    held;
        t_run           outlier_run;
        t_sample        median_mm;
        t_sample        spread_mm;
        t_total         rejects;
        t_sample        jump_gate;
        t_run           accept_run;
        t_filter_result pending_results [$];
        int unsigned    error_count;

        function new();
            foreach (window_mm[i]) window_mm[i] = '0;
            next_slot   = 0;
            held        = 0;
            outlier_run = '0;
            median_mm   = '0;
            spread_mm   = '0;
            rejects     = '0;
            jump_gate   = GATE_RESET;
            accept_run  = ACCEPT_RESET;
            error_count = 0;
        endfunction

        function void write_register(t_cfg_idx idx, t_sample data);
            if (idx == CFG_JUMP_GATE) begin
                jump_gate = data;
            end else if (idx == CFG_OUTLIER_ACCEPT) begin
                accept_run = data[RUN_W-1:0];
            end
        endfunction

        // Work out the result of one sample beat and queue it.
        function void note_sample(t_sample s);
            t_filter_result  r;
            int unsigned     sorted [WINDOW_DEPTH];
            int unsigned     v;
            int unsigned     j;
            logic [DATA_W:0] distance;
            bit              take;
            take       = 1'b1;
            r.rejected = 1'b0;
            if (held >= WINDOW_DEPTH) begin
                distance = (s > median_mm) ? {1'b0, s} - {1'b0, median_mm}
                                           : {1'b0, median_mm} - {1'b0, s};
                if (distance > {1'b0, jump_gate}) begin
                    outlier_run = outlier_run + 1'b1;
                    if (outlier_run < accept_run) begin
                        rejects    = rejects + 1'b1;
                        r.rejected = 1'b1;
                        take       = 1'b0;
                    end else begin
                        // new level: empty the window, this sample starts it
                        held        = 0;
                        next_slot   = 0;
                        outlier_run = '0;
                    end
                end else begin
                    outlier_run = '0;
                end
            end else begin
                outlier_run = '0;
            end
            if (take) begin
                window_mm[next_slot] = s;
                next_slot = (next_slot + 1) % WINDOW_DEPTH;
                if (held < WINDOW_DEPTH) held++;
                for (int i = 0; i < held; i++) begin
                    v = window_mm[i];
                    j = i;
                    while (j > 0 && sorted[j-1] > v) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = v;
                end
                if (held % 2 == 1) begin
                    median_mm = t_sample'(sorted[held/2]);
                end else begin
                    median_mm = t_sample'((sorted[held/2-1] + sorted[held/2]) / 2);
                end
                spread_mm = (held > 1) ? t_sample'(sorted[held-1] - sorted[0]) : '0;
            end
            r.median = median_mm;
            r.fill   = FILL_W'(held);
            r.spread = spread_mm;
            r.total  = rejects;
            pending_results.push_back(r);
        endfunction

        function void report_field(string field, realtime stamp,
                                   longint unsigned want, longint unsigned got);
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", stamp, field, want, got);
        endfunction

        function void check_result(t_filter_result got, realtime stamp);
            t_filter_result want;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t ns: result beat with nothing expected, median %0d fill %0d",
                         stamp, got.median, got.fill);
                return;
            end
            want = pending_results.pop_front();
            if (got.median !== want.median)
                report_field("median_mm", stamp, want.median, got.median);
            if (got.fill !== want.fill)
                report_field("fill_count", stamp, want.fill, got.fill);
            if (got.spread !== want.spread)
                report_field("spread_mm", stamp, want.spread, got.spread);
            if (got.rejected !== want.rejected)
                report_field("was_rejected", stamp, want.rejected, got.rejected);
            if (got.total !== want.total)
                report_field("reject_total", stamp, want.total, got.total);
        endfunction
    endclass

endpackage

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmof_pkg::*;
    import median_check_pkg::*;

    // Quiet cycles allowed before the run is declared hung: well above the
    // receiver hold-off plus a full-window sort.
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    // Settle beyond the time a full window takes from input beat to result.
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 7;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    t_sample           i_sample_mm    = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    t_sample           o_median_mm;
    logic [FILL_W-1:0] o_fill_count;
    t_sample           o_spread_mm;
    logic              o_was_rejected;
    t_total            o_reject_total;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index    = CFG_JUMP_GATE;
    t_sample           i_cfg_data     = '0;

    median_filter_checker sb = new();

    t_idle_mode  idle_mode    = IDLE_NONE;
    int unsigned holdoff_req  = 0;
    int unsigned holdoff_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;
    int          level_mm     = 0;

    // Directed opening: field extremes while the window fills, even and odd
    // counts, a dropped outlier run ending in an accepted jump, a sample
    // exactly on the gate, and a run broken by an in-gate sample.
    t_sample directed_mm [20] = '{
        16'd0, 16'd65535, 16'd100, 16'd200, 16'd300,
        16'd700, 16'd650, 16'd600,
        16'd610, 16'd620, 16'd590, 16'd605,
        16'd1005,
        16'd0, 16'd65535, 16'd612,
        16'd0, 16'd0, 16'd65535,
        16'd616
    };

    robust_median_outlier_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_mm    (i_sample_mm),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median_mm    (o_median_mm),
        .o_fill_count   (o_fill_count),
        .o_spread_mm    (o_spread_mm),
        .o_was_rejected (o_was_rejected),
        .o_reject_total (o_reject_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit sender_gap();
        int unsigned pct;
        pct = $urandom_range(99);
        return (idle_mode == IDLE_SENDER && pct < 62) || (idle_mode == IDLE_BOTH && pct < 11);
    endfunction

    function automatic bit receiver_stall();
        int unsigned pct;
        pct = $urandom_range(99);
        return (idle_mode == IDLE_RECEIVER && pct < 62) || (idle_mode == IDLE_BOTH && pct < 11);
    endfunction

    // Receiver: stall at random, or hold off for a long stretch on request so
    // that results back up into the block and its input stalls.
    always @(posedge i_clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            hold_left    <= HOLDOFF_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !receiver_stall();
        end
    end

    // Monitor: sample every handshake on the pre-edge values. Check a result
    // before noting a new sample; the result always belongs to an older beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(t_filter_result'{o_median_mm, o_fill_count, o_spread_mm,
                                                 o_was_rejected, o_reject_total}, $realtime);
            if (i_in_valid && o_in_ready)
                sb.note_sample(i_sample_mm);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    // Watchdog: any beat on any channel resets the quiet count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one sample beat and hold it until accepted. Lower valid only when
    // a gap is taken, so valid is never dropped and raised in one step.
    task automatic send_sample(input t_sample value);
        if (sender_gap()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (sender_gap());
        end
        i_in_valid  <= 1'b1;
        i_sample_mm <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Write the gate, then the run length; the upper byte of the run length
    // word is noise that the block must drop.
    task automatic write_regs(input t_sample gate, input t_run accept);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_JUMP_GATE;
        i_cfg_data  <= gate;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_OUTLIER_ACCEPT;
        i_cfg_data  <= t_sample'({8'($urandom), accept});
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, give the monitor an edge to note the last beat, wait for
    // every result, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample near_level(input t_sample gate);
        int span;
        int v;
        span = (gate > 4000) ? 2000 : int'(gate) / 2;
        v = level_mm + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return t_sample'(v);
    endfunction

    // Send a run of samples well outside the gate on one side of the level.
    // Move the level along if the run is long enough to be taken.
    task automatic outlier_burst(input t_sample gate, input t_run accept, input int len);
        int  margin;
        int  base;
        int  v;
        bit  up_ok;
        bit  down_ok;
        bit  upward;
        margin  = int'(gate) + int'(gate) / 2 + 200;
        up_ok   = (level_mm + margin + 200 <= 65535);
        down_ok = (level_mm - margin - 200 >= 0);
        upward  = up_ok && (!down_ok || $urandom_range(1) == 1);
        base    = upward ? level_mm + margin : level_mm - margin;
        for (int k = 0; k < len; k++) begin
            if (!up_ok && !down_ok) begin
                v = int'($urandom_range(65535));
            end else begin
                v = upward ? base + int'($urandom_range(200))
                           : base - int'($urandom_range(200));
            end
            send_sample(t_sample'(v));
        end
        if ((up_ok || down_ok) && len >= int'(accept)) level_mm = base;
    endtask

    // Mostly in-gate samples around a level, with outlier runs of random
    // length around the run limit and some plain noise.
    task automatic run_traffic(input int items, input t_sample gate, input t_run accept);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_sample(t_sample'($urandom));
                sent++;
            end else if (pick < 28) begin
                len = $urandom_range(1, (accept > 6) ? 8 : int'(accept) + 2);
                outlier_burst(gate, accept, len);
                sent += len;
            end else begin
                send_sample(near_level(gate));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        t_sample    gate;
        t_run       accept;
        t_idle_mode mode;
        int         items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset settings.
        foreach (directed_mm[i]) send_sample(directed_mm[i]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin gate = 16'd400; accept = 8'd3; mode = IDLE_NONE; items = 300; end
                1: begin gate = 16'd0; accept = 8'd1; mode = IDLE_SENDER; items = 250; end
                2: begin gate = 16'hFFFF; accept = 8'd255; mode = IDLE_RECEIVER; items = 200; end
                3: begin gate = 16'd50; accept = 8'd0; mode = IDLE_BOTH; items = 250; end
                4: begin
                    gate   = t_sample'($urandom_range(100, 3000));
                    accept = t_run'($urandom_range(1, 6));
                    mode   = IDLE_NONE;
                    items  = 300;
                end
                5: begin gate = 16'd1000; accept = 8'd255; mode = IDLE_SENDER; items = 150; end
                default: begin
                    gate   = t_sample'($urandom);
                    accept = t_run'($urandom_range(1, 255));
                    mode   = IDLE_RECEIVER;
                    items  = 200;
                end
            endcase
            write_regs(gate, accept);
            idle_mode <= mode;
            level_mm = $urandom_range(1000, 60000);
            // Hold the receiver off while the sender keeps offering beats.
            if (p == 4) holdoff_req <= holdoff_req + 1;
            if (p == 5) begin
                // Fill the window at one level, then a run long enough to
                // reach the largest run length.
                repeat (WINDOW_DEPTH) send_sample(near_level(gate));
                outlier_burst(gate, accept, 260);
            end
            run_traffic(items, gate, accept);
            drain();
        end

        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
